@@ src/rtt_pkg.sv @@
package rtt_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int TILE_SIDE = 4;
  localparam int TILES_MAX = MAX_WIDTH / TILE_SIDE;
  localparam int MAX_BANDS = 128;

  localparam int PIX_W  = 24;
  localparam int WORD_W = 32;
  localparam int BAND_W = $clog2(MAX_BANDS);
  localparam int TIDX_W = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) - 2 : 1;
  localparam int CNT_W  = TIDX_W + 2;
  localparam int ADDR_W = CNT_W + 2;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;

  localparam logic FMT_RGB5A3 = 1'b0;
  localparam logic FMT_RGBA8  = 1'b1;

  localparam logic [7:0] ALPHA_BYTE = 8'hFF;

  typedef struct packed {
    logic              mode;
    logic [TIDX_W-1:0] last_tile;
    logic [BAND_W-1:0] last_band;
  } cfg_t;

  typedef struct packed {
    logic [TIDX_W-1:0]         tile;
    logic [3:0][PIX_W-1:0]     l3;
    logic                      frame_last;
  } req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              tile_end;
    logic              frame_end;
  } out_t;

endpackage

@@ src/rtt_line_ram.sv @@
module rtt_line_ram (
  input  logic                     clk,
  input  rtt_pkg::ram_wr_t         wr,
  input  logic [rtt_pkg::ADDR_W-1:0] raddr_a,
  input  logic [rtt_pkg::ADDR_W-1:0] raddr_b,
  output logic [rtt_pkg::PIX_W-1:0]  rdata_a,
  output logic [rtt_pkg::PIX_W-1:0]  rdata_b
);
  import rtt_pkg::*;

  logic [PIX_W-1:0] mem_r [MEM_DEPTH];
  logic [PIX_W-1:0] rd_a_r;
  logic [PIX_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_a_r <= mem_r[raddr_a];
    rd_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

@@ src/rtt_req_queue.sv @@
module rtt_req_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rtt_pkg::req_t din,
  input  logic          pop,
  output rtt_pkg::req_t head,
  output logic          q_empty,
  output logic          q_full
);
  import rtt_pkg::*;

  req_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  assign head    = mem_r[rptr_r];
  assign q_empty = (cnt_r == 2'd0);
  assign q_full  = (cnt_r == 2'd2);

endmodule

@@ src/rtt_front.sv @@
module rtt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rtt_pkg::cfg_t             cfg,
  input  logic                      cfg_clear,
  input  logic                      push,
  output logic                      full,
  input  logic [rtt_pkg::PIX_W-1:0] pixel,
  input  logic                      req_full,
  input  logic                      req_empty,
  input  logic                      back_busy,
  output logic                      req_push,
  output rtt_pkg::req_t             req,
  output rtt_pkg::ram_wr_t          ram_wr,
  output logic                      band_start
);
  import rtt_pkg::*;

  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [1:0]        line_r, line_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [PIX_W-1:0]  pix_r [3];

  logic [CNT_W-1:0] last_col;
  logic             closes;
  logic             at_last_col;
  logic             accept;

  always_comb begin
    last_col    = {cfg.last_tile, 2'b11};
    closes      = (line_r == 2'd3) && (col_r[1:0] == 2'b11);
    at_last_col = (col_r == last_col);
    band_start  = (line_r == 2'd0) && (col_r == '0);
    full        = (closes && req_full) || (band_start && (!req_empty || back_busy));
    accept      = push && !full;
  end

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    band_nxt = band_r;
    if (cfg_clear) begin
      col_nxt  = '0;
      line_nxt = 2'd0;
      band_nxt = '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_nxt = '0;
        if (line_r == 2'd3) begin
          line_nxt = 2'd0;
          band_nxt = (band_r == cfg.last_band) ? '0 : band_r + 1'b1;
        end else begin
          line_nxt = line_r + 2'd1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= 2'd0;
      band_r <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      band_r <= band_nxt;
    end
  end

  // fourth line of the band travels with the request
  always_ff @(posedge clk) begin
    if (accept && (line_r == 2'd3) && !closes) begin
      pix_r[col_r[1:0]] <= pixel;
    end
  end

  always_comb begin
    ram_wr.we   = accept && (line_r != 2'd3);
    ram_wr.addr = {line_r, col_r};
    ram_wr.data = pixel;

    req_push       = accept && closes;
    req.tile       = col_r[CNT_W-1:2];
    req.l3         = {pixel, pix_r[2], pix_r[1], pix_r[0]};
    req.frame_last = at_last_col && (band_r == cfg.last_band);
  end

endmodule

@@ src/rtt_back.sv @@
module rtt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtt_pkg::cfg_t              cfg,
  input  rtt_pkg::req_t              req_head,
  input  logic                       req_empty,
  output logic                       req_pop,
  output logic                       busy,
  output logic [rtt_pkg::ADDR_W-1:0] raddr_a,
  output logic [rtt_pkg::ADDR_W-1:0] raddr_b,
  input  logic [rtt_pkg::PIX_W-1:0]  rdata_a,
  input  logic [rtt_pkg::PIX_W-1:0]  rdata_b,
  input  logic                       pop,
  output logic                       empty,
  output rtt_pkg::out_t              head
);
  import rtt_pkg::*;

  logic             active_r, active_nxt;
  logic [3:0]       k_r, k_nxt;
  req_t             cur_r;

  logic             s1_v_r;
  logic             s1_y3_r;
  logic             s1_half_r;
  logic             s1_end_r;
  logic             s1_frame_r;
  logic [PIX_W-1:0] s1_a3_r;
  logic [PIX_W-1:0] s1_b3_r;

  out_t             oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0] oq_cnt_r, oq_cnt_nxt;

  logic [OQ_CW:0]   occ;
  logic             issue;
  logic             done;
  logic             load;
  logic [3:0]       last_k;
  logic [1:0]       y;
  logic             p;
  logic             pop_ok;
  logic [PIX_W-1:0] ta, tb;
  out_t             word;

  always_comb begin
    occ     = {1'b0, oq_cnt_r} + {{OQ_CW{1'b0}}, s1_v_r};
    issue   = active_r && (occ < (OQ_CW + 1)'(OQ_DEPTH));
    last_k  = (cfg.mode == FMT_RGBA8) ? 4'd15 : 4'd7;
    done    = issue && (k_r == last_k);
    load    = !req_empty && (!active_r || done);
    req_pop = load;
    busy    = active_r;

    active_nxt = load ? 1'b1 : (done ? 1'b0 : active_r);
    k_nxt      = load ? 4'd0 : (issue ? k_r + 4'd1 : k_r);

    y       = k_r[2:1];
    p       = k_r[0];
    raddr_a = {y, cur_r.tile, p, 1'b0};
    raddr_b = {y, cur_r.tile, p, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      k_r      <= 4'd0;
      s1_v_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      k_r      <= k_nxt;
      s1_v_r   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= req_head;
    end
    if (issue) begin
      s1_y3_r    <= (y == 2'd3);
      s1_half_r  <= k_r[3];
      s1_end_r   <= (k_r == last_k);
      s1_frame_r <= (k_r == last_k) && cur_r.frame_last;
      s1_a3_r    <= cur_r.l3[{p, 1'b0}];
      s1_b3_r    <= cur_r.l3[{p, 1'b1}];
    end
  end

  always_comb begin
    ta = s1_y3_r ? s1_a3_r : rdata_a;
    tb = s1_y3_r ? s1_b3_r : rdata_b;
    if (cfg.mode == FMT_RGB5A3) begin
      word.word = {1'b1, ta[14:0], 1'b1, tb[14:0]};
    end else if (!s1_half_r) begin
      word.word = {ALPHA_BYTE, ta[23:16], ALPHA_BYTE, tb[23:16]};
    end else begin
      word.word = {ta[15:0], tb[15:0]};
    end
    word.tile_end  = s1_end_r;
    word.frame_end = s1_frame_r;
  end

  always_comb begin
    pop_ok     = pop && !empty;
    oq_cnt_nxt = oq_cnt_r + OQ_CW'(s1_v_r) - OQ_CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s1_v_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (pop_ok) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      oq_r[oq_wp_r] <= word;
    end
  end

  assign empty = (oq_cnt_r == '0);
  assign head  = oq_r[oq_rp_r];

endmodule

@@ src/raster_to_tiled_texture.sv @@
// Output: the tile closed by an accepted pixel passes the request queue, the word unit's
//   request register, the read stage and the output queue; its words follow at one per
//   cycle while the output queue has room. Input: one pixel per cycle on the first three
//   lines of a band; each tile gives 8 (16-bit) or 16 (24-bit) words from the word unit,
//   which paces the fourth line, and the first pixel of a band waits until the last tile's line-store reads are issued.
// Reset: counters and queues cleared, format 0, 160 columns, 60 rows; line store not cleared.
module raster_to_tiled_texture (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [rtt_pkg::PIX_W-1:0]    in_pixel_value,
  output logic                         empty,
  input  logic                         pop,
  output logic [rtt_pkg::WORD_W-1:0]   out_tile_word,
  output logic                         out_tile_end,
  output logic                         out_frame_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtt_pkg::PADDR_W-1:0]  paddr,
  input  logic [rtt_pkg::PDATA_W-1:0]  pwdata,
  output logic [rtt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import rtt_pkg::*;

  logic       mode_r;
  logic [8:0] cols_r;
  logic [7:0] rows_r;

  logic       cfg_wr;
  logic       cfg_clear;
  cfg_t       cfg;

  logic       req_push, req_pop, req_full, req_empty;
  req_t       req_in, req_head;
  ram_wr_t    ram_wr;
  logic       back_busy;
  logic       band_start;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [PIX_W-1:0]  rdata_a, rdata_b;
  out_t       oq_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_FORMAT, REG_COLUMNS, REG_ROWS: cfg_clear = 1'b1;
        default:                           cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= FMT_RGB5A3;
      cols_r <= 9'd160;
      rows_r <= 8'd60;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FORMAT:  mode_r <= pwdata[0];
        REG_COLUMNS: cols_r <= pwdata[8:0];
        REG_ROWS:    rows_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FORMAT:  prdata = {{(PDATA_W-1){1'b0}}, mode_r};
      REG_COLUMNS: prdata = {{(PDATA_W-9){1'b0}}, cols_r};
      REG_ROWS:    prdata = {{(PDATA_W-8){1'b0}}, rows_r};
      default:     prdata = '0;
    endcase
  end

  // zero acts as one, large values saturate
  always_comb begin
    cfg.mode = mode_r;
    if (cols_r == 9'd0) begin
      cfg.last_tile = '0;
    end else if (int'(cols_r) > TILES_MAX) begin
      cfg.last_tile = TIDX_W'(TILES_MAX - 1);
    end else begin
      cfg.last_tile = TIDX_W'(cols_r - 9'd1);
    end
    if (rows_r == 8'd0) begin
      cfg.last_band = '0;
    end else if (int'(rows_r) > MAX_BANDS) begin
      cfg.last_band = BAND_W'(MAX_BANDS - 1);
    end else begin
      cfg.last_band = BAND_W'(rows_r - 8'd1);
    end
  end

  rtt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_clear  (cfg_clear),
    .push       (push),
    .full       (full),
    .pixel      (in_pixel_value),
    .req_full   (req_full),
    .req_empty  (req_empty),
    .back_busy  (back_busy),
    .req_push   (req_push),
    .req        (req_in),
    .ram_wr     (ram_wr),
    .band_start (band_start)
  );

  rtt_line_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  rtt_req_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (req_push),
    .din     (req_in),
    .pop     (req_pop),
    .head    (req_head),
    .q_empty (req_empty),
    .q_full  (req_full)
  );

  rtt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_head  (req_head),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .busy      (back_busy),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .pop       (pop),
    .empty     (empty),
    .head      (oq_head)
  );

  assign out_tile_word = oq_head.word;
  assign out_tile_end  = oq_head.tile_end;
  assign out_frame_end = oq_head.frame_end;

`ifndef ASSERT_OFF
  a_frame_end_on_tile_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_tile_end)
    else $error("frame end without tile end");

  a_req_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    req_push |-> !req_full)
    else $error("request queue overflow");

  a_band_start_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && band_start) |-> (req_empty && !back_busy))
    else $error("line store overwritten while tile reads pending");

  a_cfg_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> band_start)
    else $error("register write did not restart frame");
`endif

endmodule

@@ tb/tb_raster_to_tiled_texture.sv @@
`timescale 1ns / 100ps

module tb_raster_to_tiled_texture;
  import rtt_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [PIX_W-1:0]    in_pixel_value;
  logic                empty;
  logic                pop;
  logic [WORD_W-1:0]   out_tile_word;
  logic                out_tile_end;
  logic                out_frame_end;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  raster_to_tiled_texture dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_pixel_value (in_pixel_value),
    .empty          (empty),
    .pop            (pop),
    .out_tile_word  (out_tile_word),
    .out_tile_end   (out_tile_end),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: register mirror, raster position and band store
  logic              cfg_fmt;
  logic [8:0]        cfg_cols;
  logic [7:0]        cfg_rows;
  int                pos_col;
  int                pos_line;
  int                pos_band;
  logic [PIX_W-1:0]  band_store [4][MAX_WIDTH];

  out_t expected_words [$];

  int  pixels_sent;
  int  tiles_due;
  int  words_seen;
  int  cfg_writes;
  int  fail_count;
  int  pop_stall;
  bit  quiet_in;
  bit  quiet_out;

  function automatic int eff_cols();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > TILES_MAX) return TILES_MAX;
    return int'(cfg_cols);
  endfunction

  function automatic int eff_rows();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > MAX_BANDS) return MAX_BANDS;
    return int'(cfg_rows);
  endfunction

  task automatic predict_tiles(input logic [PIX_W-1:0] pix);
    int               width;
    int               col;
    int               base;
    int               n;
    logic [31:0]      w [16];
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    bit               closes;
    bit               last_tile;
    out_t             e;
    width = eff_cols() * TILE_SIDE;
    col = (pos_col >= width) ? width - 1 : pos_col;
    band_store[pos_line][col] = pix;
    closes = (pos_line == 3) && (col % 4 == 3);
    last_tile = closes && (col == width - 1) && (pos_band + 1 >= eff_rows());
    n = 0;
    if (closes) begin
      base = col - 3;
      for (int y = 0; y < 4; y++) begin
        for (int p = 0; p < 2; p++) begin
          a = band_store[y][base + 2 * p];
          b = band_store[y][base + 2 * p + 1];
          if (cfg_fmt == FMT_RGB5A3) begin
            w[n] = {1'b1, a[14:0], 1'b1, b[14:0]};
          end else begin
            w[n] = {ALPHA_BYTE, a[23:16], ALPHA_BYTE, b[23:16]};
            w[n + 8] = {a[15:0], b[15:0]};
          end
          n++;
        end
      end
      if (cfg_fmt == FMT_RGBA8) n = 16;
      for (int k = 0; k < n; k++) begin
        e.word = w[k];
        e.tile_end = (k == n - 1);
        e.frame_end = (k == n - 1) && last_tile;
        expected_words.push_back(e);
      end
      tiles_due++;
    end
    if (col + 1 >= width) begin
      pos_col = 0;
      if (pos_line == 3) begin
        pos_line = 0;
        pos_band = (pos_band + 1 >= eff_rows()) ? 0 : pos_band + 1;
      end else begin
        pos_line = pos_line + 1;
      end
    end else begin
      pos_col = col + 1;
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (full);
    pixels_sent++;
    predict_tiles(pix);
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // called at a falling edge; leaves the block with nothing in flight
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_writes++;
    if (idx != REG_UNUSED) begin
      case (idx)
        REG_FORMAT:  cfg_fmt  = val[0];
        REG_COLUMNS: cfg_cols = val[8:0];
        REG_ROWS:    cfg_rows = val[7:0];
        default: ;
      endcase
      pos_col = 0;
      pos_line = 0;
      pos_band = 0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame(input logic fmt, input int cols, input int rows);
    cfg_write(REG_FORMAT, 32'(fmt));
    cfg_write(REG_COLUMNS, 32'(cols));
    cfg_write(REG_ROWS, 32'(rows));
  endtask

  task automatic note_fail(input string what, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic cfg_read_check(input logic [1:0] idx, input logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) note_fail("register read", want, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // pop side: random stalls between requests
  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && pop && !empty) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected word %h", $realtime, out_tile_word);
      end else begin
        want = expected_words.pop_front();
        if (out_tile_word !== want.word) note_fail("tile_word", want.word, out_tile_word);
        if (out_tile_end !== want.tile_end)
          note_fail("tile_end", 32'(want.tile_end), 32'(out_tile_end));
        if (out_frame_end !== want.frame_end)
          note_fail("frame_end", 32'(want.frame_end), 32'(out_frame_end));
      end
      if ($urandom_range(0, 47) == 0) quiet_out = !quiet_out;
      pop_stall = quiet_out ? 0 : $urandom_range(0, 8);
    end
  end

  // defaults after reset read back; then one 16-bit tile, 60 rows so no frame end
  task automatic test_reset_values();
    cfg_read_check(REG_FORMAT, 32'(FMT_RGB5A3));
    cfg_read_check(REG_COLUMNS, 32'd160);
    cfg_read_check(REG_ROWS, 32'd60);
    cfg_write(REG_COLUMNS, 32'd1);
    send_random(16);
    wait_idle();
  endtask

  task automatic test_rgba8_extremes();
    logic [PIX_W-1:0] pat [16];
    pat = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h800000,
            24'h008000, 24'h000080, 24'h7FFFFF, 24'hFF7FFF, 24'hFFFF7F, 24'h010101,
            24'h123456, 24'hABCDEF, 24'h00FFFF, 24'hFFFF00};
    set_frame(FMT_RGBA8, 1, 1);
    for (int i = 0; i < 16; i++) send_pixel(pat[i]);
    wait_idle();
  endtask

  // zero columns acts as one; a width beyond the store gives no early tile
  task automatic test_width_limits();
    set_frame(FMT_RGB5A3, 0, 2);
    send_random(32);
    wait_idle();
    set_frame(FMT_RGB5A3, 511, 1);
    send_random(24);
    wait_idle();
  endtask

  // zero rows acts as one; a height above 128 bands gives no early frame end
  task automatic test_height_limits();
    set_frame(FMT_RGB5A3, 1, 0);
    send_random(32);
    wait_idle();
    set_frame(FMT_RGBA8, 1, 255);
    send_random(32);
    wait_idle();
  endtask

  // a register write restarts the frame; an unmapped address leaves the position alone
  task automatic test_position_clear();
    set_frame(FMT_RGB5A3, 2, 2);
    send_random(20);
    wait_idle();
    cfg_write(REG_UNUSED, 32'h1FF);
    send_random(12);
    send_random(10);
    wait_idle();
    cfg_write(REG_ROWS, 32'd2);
    send_random(32);
    wait_idle();
    send_random(5);
    wait_idle();
    cfg_write(REG_FORMAT, 32'(FMT_RGBA8));
    send_random(32);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int start_px;
    int width;
    int count;
    start_px = pixels_sent;
    while (pixels_sent - start_px < 40) begin
      if ($urandom_range(0, 1)) cfg_write(REG_FORMAT, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 7))
        0: cfg_write(REG_COLUMNS, 32'd0);
        1, 2, 3: cfg_write(REG_COLUMNS, 32'($urandom_range(1, 2)));
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: cfg_write(REG_ROWS, 32'($urandom_range(129, 255)));
        1, 2: cfg_write(REG_ROWS, 32'($urandom_range(0, 3)));
        3: cfg_write(REG_UNUSED, $urandom);
        default: ;
      endcase
      width = eff_cols() * TILE_SIDE;
      count = width * 4;
      if ($urandom_range(0, 2) == 0) count += $urandom_range(1, width * 4);
      send_random(count);
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_pixel_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_fmt = FMT_RGB5A3;
    cfg_cols = 9'd160;
    cfg_rows = 8'd60;
    pos_col = 0;
    pos_line = 0;
    pos_band = 0;
    pixels_sent = 0;
    tiles_due = 0;
    words_seen = 0;
    cfg_writes = 0;
    fail_count = 0;
    pop_stall = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_rgba8_extremes();
    test_width_limits();
    test_height_limits();
    test_position_clear();
    test_random_frames();

    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Run: %0d pixels in, %0d tiles / %0d words out, %0d register writes",
             pixels_sent, tiles_due, words_seen, cfg_writes);
    $display("Both formats, clamped widths and heights, frame restarts; %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("** raster_to_tiled_texture: PASSED **");
    end else begin
      $display("** raster_to_tiled_texture: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d words outstanding", expected_words.size());
    $display("** raster_to_tiled_texture: FAILED **");
    $finish;
  end

endmodule
